### hw/rtl/scdf_pkg.sv
// Types and constants shared by the sequenced channel datagram filter.
// Holds the parse phase, class and verdict codes and the beat payload structs.
// No dependencies.
`timescale 1ns / 1ps

package scdf_pkg;

  // Parse position inside a datagram.
  typedef enum logic [2:0] {
    PH_CLASS   = 3'd0,
    PH_CHANNEL = 3'd1,
    PH_SEQ0    = 3'd2,
    PH_SEQ1    = 3'd3,
    PH_SEQ2    = 3'd4,
    PH_SEQ3    = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    CLS_UNRELIABLE = 2'd0,
    CLS_SEQUENCED  = 2'd1,
    CLS_OTHER      = 2'd2
  } class_e;

  typedef enum logic [2:0] {
    V_PROGRESS  = 3'd0,
    V_ACCEPTED  = 3'd1,
    V_TOO_SHORT = 3'd2,
    V_BAD_CHAN  = 3'd3,
    V_STALE     = 3'd4
  } verdict_e;

  localparam int unsigned SeqW = 32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       route;
    logic       message_done;
    logic [2:0] verdict;
  } out_beat_t;

endpackage

### hw/rtl/scdf_stream_if.sv
// Valid/ready stream interface carrying one payload beat per handshake.
// The payload type is a parameter; no other dependencies.
`timescale 1ns / 1ps

interface scdf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/scdf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read data holds until the next read enable. No dependencies.
`timescale 1ns / 1ps

module scdf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/sequenced_channel_datagram_filter.sv
// Sequenced channel datagram filter: one result beat for every input beat.
// Each result beat is registered; throughput is one beat per cycle while out_o.ready
// holds, and a new beat is taken while the result register is drained.
// Per-channel highest sequence lives in a RAM read on the channel byte and written
// on the last sequence byte; per-entry valid bits make it read as zero after reset.
// Reset (rst_ni low, asynchronous) returns the parser to the class byte at once.
`timescale 1ns / 1ps

module sequenced_channel_datagram_filter #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  scdf_stream_if.sink   in_i,
  scdf_stream_if.source out_o
);

  import scdf_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  phase_e          phase_q, phase_d;
  class_e          class_q, class_d;
  logic [7:0]      channel_q, channel_d;
  logic [23:0]     seq_q, seq_d;
  logic            dropping_q, dropping_d;
  logic [CHANNELS-1:0] valid_q, valid_d;

  logic            out_valid_q;
  out_beat_t       out_q, out_d;

  logic            accept;
  in_beat_t        beat;
  logic [IdxW-1:0] chan_idx;
  logic            chan_bad;
  logic [SeqW-1:0] seq_full;
  logic [SeqW-1:0] high_seq;
  logic [SeqW-1:0] seq_diff;
  logic            stale;
  logic            ram_re;
  logic            ram_we;
  logic [SeqW-1:0] ram_rdata;
  verdict_e        verdict;
  verdict_e        end_verdict;

  assign beat     = in_i.payload;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;

  // Channel bytes at or above CHANNELS are bad, compared unsigned; CHANNELS must not exceed 128 (not checked).
  assign chan_idx = channel_q[IdxW-1:0];
  assign chan_bad = (channel_q >= 8'(CHANNELS));
  assign seq_full = {beat.data_byte, seq_q};
  assign high_seq = valid_q[chan_idx] ? ram_rdata : '0;
  assign seq_diff = seq_full - high_seq;
  assign stale    = (seq_diff == '0) || seq_diff[SeqW-1];

  assign ram_re = accept && (phase_q == PH_CHANNEL);
  assign ram_we = accept && (phase_q == PH_SEQ3) && !chan_bad && !stale;

  scdf_ram #(
    .Width (SeqW),
    .Depth (CHANNELS)
  ) u_high_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (chan_idx),
    .wdata_i (seq_full),
    .re_i    (ram_re),
    .raddr_i (beat.data_byte[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    phase_d     = phase_q;
    class_d     = class_q;
    channel_d   = channel_q;
    seq_d       = seq_q;
    dropping_d  = dropping_q;
    valid_d     = valid_q;
    verdict     = V_PROGRESS;
    end_verdict = dropping_q ? (chan_bad ? V_BAD_CHAN : V_STALE) : V_ACCEPTED;
    out_d       = '0;

    unique case (phase_q)
      PH_CLASS: begin
        priority if (beat.data_byte == 8'd0) begin
          class_d = CLS_UNRELIABLE;
        end else if (beat.data_byte == 8'd1) begin
          class_d = CLS_SEQUENCED;
        end else begin
          class_d = CLS_OTHER;
        end
        dropping_d = 1'b0;
        if (beat.last_byte) begin
          verdict = (class_d == CLS_SEQUENCED) ? V_TOO_SHORT : V_ACCEPTED;
        end else begin
          phase_d = (class_d == CLS_SEQUENCED) ? PH_CHANNEL : PH_PAYLOAD;
        end
      end
      PH_CHANNEL: begin
        channel_d = beat.data_byte;
        if (beat.last_byte) begin
          verdict = V_TOO_SHORT;
        end else begin
          phase_d = PH_SEQ0;
        end
      end
      PH_SEQ0, PH_SEQ1, PH_SEQ2: begin
        unique case (phase_q)
          PH_SEQ0: seq_d[7:0]   = beat.data_byte;
          PH_SEQ1: seq_d[15:8]  = beat.data_byte;
          default: seq_d[23:16] = beat.data_byte;
        endcase
        if (beat.last_byte) begin
          verdict = V_TOO_SHORT;
        end else begin
          phase_d = phase_e'(phase_q + 3'd1);
        end
      end
      PH_SEQ3: begin
        if (chan_bad || stale) begin
          dropping_d = 1'b1;
        end else begin
          valid_d[chan_idx] = 1'b1;
        end
        if (beat.last_byte) begin
          if (chan_bad) begin
            verdict = V_BAD_CHAN;
          end else if (stale) begin
            verdict = V_STALE;
          end else begin
            verdict = V_ACCEPTED;
          end
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (!dropping_q) begin
          out_d.payload_valid = 1'b1;
          out_d.payload_byte  = beat.data_byte;
        end
        if (beat.last_byte) begin
          verdict = end_verdict;
        end
      end
      default: begin
        phase_d = PH_CLASS;
      end
    endcase

    out_d.route        = (class_d == CLS_OTHER);
    out_d.message_done = beat.last_byte;
    out_d.verdict      = verdict;

    if (beat.last_byte) begin
      phase_d    = PH_CLASS;
      dropping_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CLASS;
      class_q     <= CLS_UNRELIABLE;
      channel_q   <= '0;
      seq_q       <= '0;
      dropping_q  <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q    <= phase_d;
        class_q    <= class_d;
        channel_q  <= channel_d;
        seq_q      <= seq_d;
        dropping_q <= dropping_d;
        valid_q    <= valid_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // The highest-sequence RAM is never read and written in the same cycle.
  a_ram_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_re && ram_we))
    else $error("highest-sequence RAM read and write collide");

  // A passing sequence marks its channel entry as written.
  a_valid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(chan_idx)])
    else $error("channel entry not marked valid after update");

  // Only the result for a last byte carries a final verdict.
  a_verdict_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.message_done |-> out_q.verdict == V_PROGRESS)
    else $error("final verdict on a beat that does not end the datagram");

  // A beat that is not forwarded carries a zero payload byte.
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.payload_valid |-> out_q.payload_byte == 8'd0)
    else $error("payload byte set on a beat that is not forwarded");

endmodule

### test/tb_sequenced_channel_datagram_filter.sv
// Self-checking testbench for the sequenced channel datagram filter.
// Sends datagrams byte by byte and checks every result beat against a predictor.
// Depends on scdf_pkg, scdf_stream_if and the filter RTL.
`timescale 1ns / 1ps

module tb_sequenced_channel_datagram_filter;
  import scdf_pkg::*;

  localparam int unsigned NumChannels = 8;
  localparam int unsigned ChanIdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int RandomBeats = 600;

  logic clk_i;
  logic rst_ni;

  scdf_stream_if #(.payload_t(in_beat_t))  in_if ();
  scdf_stream_if #(.payload_t(out_beat_t)) out_if ();

  sequenced_channel_datagram_filter #(
    .CHANNELS(NumChannels)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Tracks the parser state and the per-channel highest sequence, and holds
  // the result beats that are still owed by the block.
  class datagram_scoreboard;
    phase_e      phase;
    class_e      dg_class;
    logic [7:0]  channel;
    logic [31:0] seq_acc;
    bit          dropping;
    logic [31:0] highest[NumChannels];
    out_beat_t   owed[$];
    int          errors;
    int          beats_checked;
    int          verdict_count[5];

    function new();
      phase    = PH_CLASS;
      dg_class = CLS_UNRELIABLE;
      channel  = '0;
      seq_acc  = '0;
      dropping = 1'b0;
      foreach (highest[i]) highest[i] = '0;
      errors        = 0;
      beats_checked = 0;
      foreach (verdict_count[i]) verdict_count[i] = 0;
    endfunction

    function verdict_e end_verdict();
      if (!dropping) return V_ACCEPTED;
      return (channel >= 8'(NumChannels)) ? V_BAD_CHAN : V_STALE;
    endfunction

    function void note_input(in_beat_t b);
      out_beat_t   e;
      logic [31:0] diff;
      e = '0;
      e.verdict = V_PROGRESS;
      e.message_done = b.last_byte;
      case (phase)
        PH_CLASS: begin
          dg_class = (b.data_byte == 8'd0) ? CLS_UNRELIABLE :
                     (b.data_byte == 8'd1) ? CLS_SEQUENCED : CLS_OTHER;
          dropping = 1'b0;
          seq_acc  = '0;
          if (b.last_byte) begin
            e.verdict = (dg_class == CLS_SEQUENCED) ? V_TOO_SHORT : V_ACCEPTED;
          end else begin
            phase = (dg_class == CLS_SEQUENCED) ? PH_CHANNEL : PH_PAYLOAD;
          end
        end
        PH_CHANNEL: begin
          channel = b.data_byte;
          if (b.last_byte) e.verdict = V_TOO_SHORT;
          else phase = PH_SEQ0;
        end
        PH_SEQ0, PH_SEQ1, PH_SEQ2: begin
          seq_acc = seq_acc | (32'(b.data_byte) << (8 * (int'(phase) - int'(PH_SEQ0))));
          if (b.last_byte) e.verdict = V_TOO_SHORT;
          else phase = phase_e'(int'(phase) + 1);
        end
        PH_SEQ3: begin
          seq_acc[31:24] = b.data_byte;
          if (channel >= 8'(NumChannels)) begin
            dropping = 1'b1;
          end else begin
            // Newer means a positive, nonzero difference modulo 2^32.
            diff = seq_acc - highest[channel[ChanIdxW-1:0]];
            if (diff == 32'd0 || diff[31]) dropping = 1'b1;
            else highest[channel[ChanIdxW-1:0]] = seq_acc;
          end
          if (b.last_byte) e.verdict = end_verdict();
          else phase = PH_PAYLOAD;
        end
        default: begin
          if (!dropping) begin
            e.payload_valid = 1'b1;
            e.payload_byte  = b.data_byte;
          end
          if (b.last_byte) e.verdict = end_verdict();
        end
      endcase
      e.route = (dg_class == CLS_OTHER);
      if (b.last_byte) begin
        phase    = PH_CLASS;
        dropping = 1'b0;
        seq_acc  = '0;
        verdict_count[e.verdict]++;
      end
      owed.push_back(e);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp;
      beats_checked++;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: byte %h valid %b route %b done %b verdict %0d",
                 $time, got.payload_byte, got.payload_valid, got.route,
                 got.message_done, got.verdict);
        return;
      end
      exp = owed.pop_front();
      if (got.payload_byte !== exp.payload_byte || got.payload_valid !== exp.payload_valid ||
          got.route !== exp.route || got.message_done !== exp.message_done ||
          got.verdict !== exp.verdict) begin
        errors++;
        $display("%0t: mismatch: expected byte %h valid %b route %b done %b verdict %0d",
                 $time, exp.payload_byte, exp.payload_valid, exp.route,
                 exp.message_done, exp.verdict);
        $display("%0t:           actual   byte %h valid %b route %b done %b verdict %0d",
                 $time, got.payload_byte, got.payload_valid, got.route,
                 got.message_done, got.verdict);
      end
    endfunction
  endclass

  datagram_scoreboard sb;
  int beats_sent;
  int datagrams_sent;
  bit send_quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Timeout at %0t", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Drives one byte; valid stays high into the next beat when no gap is drawn.
  task automatic send_beat(input logic [7:0] data, input logic last);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= '{data_byte: data, last_byte: last};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input('{data_byte: data, last_byte: last});
    beats_sent++;
  endtask

  task automatic send_datagram(input logic [7:0] bytes[$]);
    if ($urandom_range(0, 7) == 0) send_quiet = ~send_quiet;
    foreach (bytes[i]) send_beat(bytes[i], i == bytes.size() - 1);
    datagrams_sent++;
  endtask

  task automatic add_payload(ref logic [7:0] bytes[$]);
    int len;
    len = $urandom_range(0, 12);
    repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_datagram();
    logic [7:0]  bytes[$];
    logic [7:0]  ch;
    logic [31:0] base;
    logic [31:0] seqn;
    int          kind;
    int          pick;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      // Complete sequenced header, mostly on a valid channel.
      ch = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NumChannels, 255))
                                       : 8'($urandom_range(0, NumChannels - 1));
      base = (ch < 8'(NumChannels)) ? sb.highest[ch[ChanIdxW-1:0]] : $urandom;
      pick = $urandom_range(0, 19);
      if (pick < 10) seqn = base + $urandom_range(1, 1000);
      else if (pick < 12) seqn = base;
      else if (pick < 14) seqn = base - $urandom_range(1, 1000);
      else if (pick < 16) seqn = base + 32'h7FFF_FFFF;
      else if (pick < 17) seqn = base + 32'h8000_0000;
      else seqn = $urandom;
      bytes = '{8'd1, ch, seqn[7:0], seqn[15:8], seqn[23:16], seqn[31:24]};
      add_payload(bytes);
    end else if (kind < 75) begin
      // Sequenced datagram cut off before its header is complete.
      bytes.push_back(8'd1);
      repeat ($urandom_range(0, 4)) bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 85) begin
      bytes.push_back(8'd0);
      add_payload(bytes);
    end else if (kind < 95) begin
      bytes.push_back(8'($urandom_range(2, 255)));
      add_payload(bytes);
    end else begin
      repeat ($urandom_range(1, 8)) bytes.push_back(8'($urandom_range(0, 255)));
    end
    send_datagram(bytes);
  endtask

  // Result side: may draw a random stall before each beat it takes.
  initial begin
    int  gap;
    bit  quiet;
    out_if.ready <= 1'b0;
    quiet = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet = ~quiet;
      gap = quiet ? 0 : $urandom_range(0, 17);
      repeat (gap) begin
        out_if.ready <= 1'b0;
        @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      sb.check_result(out_if.payload);
    end
  end

  initial begin
    sb = new();
    beats_sent     = 0;
    datagrams_sent = 0;
    send_quiet     = 1'b0;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: class byte alone for each class, payload extremes,
    // headers cut short, an empty sequenced payload and an out-of-range channel.
    send_datagram('{8'h00});
    send_datagram('{8'h01});
    send_datagram('{8'hFF});
    send_datagram('{8'h00, 8'hFF, 8'h00});
    send_datagram('{8'h01, 8'h02});
    send_datagram('{8'h01, 8'h07, 8'h10, 8'h20});
    send_datagram('{8'h01, 8'h07, 8'h01, 8'h00, 8'h00, 8'h00});
    send_datagram('{8'h01, 8'h80, 8'h05, 8'h00, 8'h00, 8'h00, 8'hAA});

    while (beats_sent < RandomBeats + 25) send_random_datagram();
    in_if.valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d datagrams in %0d beats; checked %0d result beats.",
             datagrams_sent, beats_sent, sb.beats_checked);
    $display("Verdicts: accepted %0d, too short %0d, bad channel %0d, stale %0d.",
             sb.verdict_count[V_ACCEPTED], sb.verdict_count[V_TOO_SHORT],
             sb.verdict_count[V_BAD_CHAN], sb.verdict_count[V_STALE]);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/scdf_pkg.sv
hw/rtl/scdf_stream_if.sv
hw/rtl/scdf_ram.sv
hw/rtl/sequenced_channel_datagram_filter.sv
test/tb_sequenced_channel_datagram_filter.sv
